// ===== rtl/core/hmmfwd_pkg.sv =====
// shared types, constants and helpers of the hmm forward likelihood core
package hmmfwd_pkg;

  localparam int unsigned NSTATES    = 8;
  localparam int unsigned MAX_LEVELS = 4;
  localparam int unsigned IN_DATA_W  = 160;
  localparam int unsigned OUT_DATA_W = 80;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 17;

  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam logic [23:0] LN2_Q24 = 24'd11629080;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_BEGIN = 2'd1,
    MODE_STEP  = 2'd2,
    MODE_END   = 2'd3
  } mode_e;

  localparam logic [CFG_IDX_W-1:0] CFG_LEVELS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIX_A  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIX_B  = 2'd2;

  function automatic logic [16:0] clampq(input logic [16:0] v);
    clampq = (v[16] && (|v[15:0])) ? ONE_Q16 : v;
  endfunction

endpackage

// ===== rtl/core/hmm_forward_loglikelihood_core.sv =====
// hmm forward log likelihood core: sequencer, shared multiplier, alpha and emission rams
//
// channel   | dir | transfer when              | content
// s_axis    | in  | s_axis_tvalid&s_axis_tready | mode in tuser, step/load fields in tdata
// m_axis    | out | m_axis_tvalid&m_axis_tready | term and running total
// cfg       | in  | cfg_valid_i&cfg_ready_o     | register index and write data
//
// load and begin leave the core idle, config is always ready; a step is paced by the
// single 36x17 multiplier (6 products for the transition, 18 per chain)
// plus the eight-entry read and write passes of the alpha ram for each chain.
// an end item is spent mostly in the 20 squarings of the log unit.
// reset clears control, alpha valid bits, scales and total; no clearing pass.
// a finished term waits in the output register while the next items are taken.
module hmm_forward_loglikelihood_core #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [hmmfwd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [hmmfwd_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // surv, entry, infect, lam, obs, combo, err_one, err_two, err_three, weight
  input  logic [hmmfwd_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // mode
  input  logic [1:0]                          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // term, total
  output logic [hmmfwd_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

  import hmmfwd_pkg::*;

  localparam int unsigned TAW = $clog2(TABLE_DEPTH);

  typedef enum logic [3:0] {
    ST_IDLE, ST_GCALC, ST_RD, ST_ACC, ST_VMUL, ST_NORM, ST_WR, ST_SUMRD,
    ST_XMUL, ST_ALIGN, ST_LOGN, ST_LOGSQ, ST_LNMUL, ST_TMUL, ST_FIN
  } state_e;

  state_e      state_q;
  logic [4:0]  cnt_q;
  logic        chain_q;
  logic        out_valid_q;
  logic [15:0] avld_q;
  logic [1:0][15:0] scale_q;
  logic [47:0] running_q;
  logic [2:0]  levels_q;
  logic [16:0] wa_q, wb_q;

  logic [16:0] surv_q, entry_q, infect_q, lam_q, e1_q, e2_q, e3_q;
  logic [9:0]  obs_q;
  logic [7:0]  combo_q;
  logic [15:0] weight_q;
  logic [16:0] g0_q, g2_q, g3_q, g4_q, g5_q, sej_q, g1;
  logic [31:0] a_q   [NSTATES];
  logic [50:0] acc_q [NSTATES];
  logic [35:0] v_q   [NSTATES];
  logic [35:0] mx_q;
  logic [5:0]  r_q;
  logic        shr_q;
  logic        rdv_q, rds0_q;
  logic [34:0] sa_q, sb_q;
  logic [51:0] xa_q, xb_q;
  logic [52:0] x_q;
  logic [15:0] smin_q;
  logic [5:0]  p_q;
  logic [30:0] m_q;
  logic [19:0] frac_q;
  logic        zero_q, neg_q;
  logic [38:0] mag_q;
  logic [62:0] lnp_q;
  logic [49:0] tmag_q;
  logic [31:0] term_q;
  logic [47:0] total_q;
  logic [52:0] prod_q;

  logic        in_acc;
  mode_e       in_mode;
  logic [9:0]  in_obs;
  logic [3:0]  op;
  logic        ph;

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_mode       = mode_e'(s_axis_tuser);
  assign in_obs        = s_axis_tdata[77:68];
  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {total_q, term_q};
  assign op            = cnt_q[4:1];
  assign ph            = cnt_q[0];
  assign g1            = 17'(ONE_Q16 - surv_q);

  // emission decode
  logic [2:0]  lv, sh;
  logic [15:0] blk, half, ob, kt, kf, idx;
  logic        present, st0, st6, one1, one2, tok, kt_hit, kf_hit;
  logic [33:0] td;
  logic [16:0] tv;
  logic [16:0] em [NSTATES];

  always_comb begin
    lv = levels_q;
    if (lv < 3'd1) lv = 3'd1;
    if (lv > 3'(MAX_LEVELS)) lv = 3'(MAX_LEVELS);
    sh      = (lv >= 3'd2) ? 3'(lv - 3'd2) : 3'd0;
    blk     = 16'd64 << sh;
    half    = (lv >= 3'd3) ? (16'd1 << 3'(lv - 3'd3)) : 16'd0;
    kt      = (16'(combo_q) << sh) - 16'd1;
    kf      = kt - half;
    present = (obs_q != 10'd0);
    ob      = 16'(obs_q) - 16'd1;
    st0 = 1'b0; st6 = 1'b0; one1 = 1'b0; one2 = 1'b0; idx = '0;
    if (present) begin
      if (ob < blk) begin
        st0 = 1'b1; idx = ob;
      end else if (ob == blk) begin
        one1 = 1'b1;
      end else if (ob == blk + 16'd1) begin
        one2 = 1'b1;
      end else if (ob >= blk + 16'd2 && ob < (blk << 1) + 16'd2) begin
        st6 = 1'b1; idx = ob - blk - 16'd2;
      end
    end
    tok    = (st0 || st6) && (idx < 16'(TABLE_DEPTH));
    kt_hit = present && (ob == kt);
    kf_hit = present && (half != 16'd0) && (ob == kf);
    tv     = chain_q ? clampq(td[33:17]) : clampq(td[16:0]);
    em[0]  = (st0 && tok) ? tv : '0;
    em[6]  = (st6 && tok) ? tv : '0;
    em[1]  = one1 ? ONE_Q16 : '0;
    em[2]  = one2 ? ONE_Q16 : '0;
    em[3]  = kt_hit ? ONE_Q16 : '0;
    em[4]  = kf_hit ? e1_q : (kt_hit ? 17'(ONE_Q16 - e1_q) : '0);
    em[5]  = kf_hit ? e2_q : (kt_hit ? 17'(ONE_Q16 - e2_q) : '0);
    em[7]  = kf_hit ? e3_q : (kt_hit ? 17'(ONE_Q16 - e3_q) : '0);
  end

  // rams
  logic        tbl_we;
  logic [3:0]  araddr, awaddr;
  logic [31:0] arddata, awdata, aval;
  logic        awe;

  assign tbl_we = in_acc && (in_mode == MODE_LOAD) && ({1'b0, in_obs} < 11'(TABLE_DEPTH));

  hmmfwd_ram #(.WIDTH(34), .DEPTH(TABLE_DEPTH)) u_tbl (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (in_obs[TAW-1:0]),
    .wdata_i ({s_axis_tdata[33:17], s_axis_tdata[16:0]}),
    .raddr_i (idx[TAW-1:0]),
    .rdata_o (td)
  );

  hmmfwd_ram #(.WIDTH(32), .DEPTH(2 * NSTATES)) u_alpha (
    .clk_i   (clk_i),
    .we_i    (awe),
    .waddr_i (awaddr),
    .wdata_i (awdata),
    .raddr_i (araddr),
    .rdata_o (arddata)
  );

  assign aval = rdv_q ? arddata : (rds0_q ? 32'h8000_0000 : 32'd0);

  always_comb begin
    case (state_q)
      ST_RD:    araddr = {chain_q, cnt_q[2:0]};
      ST_SUMRD: araddr = cnt_q[3:0];
      default:  araddr = '0;
    endcase
  end

  // shared multiplier operands
  logic [32:0] a06, a23;
  logic [33:0] a234, a157;
  logic [51:0] accr;
  logic [62:0] lnrr;
  logic [35:0] mul_a;
  logic [16:0] mul_b;
  logic [52:0] prnd;
  logic [36:0] rq;

  assign a06  = 33'(a_q[0]) + 33'(a_q[6]);
  assign a23  = 33'(a_q[2]) + 33'(a_q[3]);
  assign a234 = 34'(a23) + 34'(a_q[4]);
  assign a157 = 34'(a_q[1]) + 34'(a_q[5]) + 34'(a_q[7]);
  assign accr = 52'(acc_q[op[2:0]]) + 52'd32768;
  assign lnrr = lnp_q + 63'(1 << 27);
  assign prnd = prod_q + 53'd32768;
  assign rq   = prnd[52:16];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_GCALC: begin
        case (op)
          4'd0: begin mul_a = 36'(surv_q); mul_b = 17'(ONE_Q16 - entry_q); end
          4'd1: begin mul_a = 36'(surv_q); mul_b = entry_q; end
          4'd2: begin mul_a = 36'(lam_q); mul_b = sej_q; end
          4'd3: begin mul_a = 36'(17'(ONE_Q16 - lam_q)); mul_b = sej_q; end
          4'd4: begin mul_a = 36'(surv_q); mul_b = infect_q; end
          default: begin mul_a = 36'(surv_q); mul_b = 17'(ONE_Q16 - infect_q); end
        endcase
      end
      ST_ACC: begin
        case (op)
          4'd0: begin mul_a = 36'(a06); mul_b = g0_q; end
          4'd1: begin mul_a = 36'(a_q[4]); mul_b = g4_q; end
          4'd2: begin mul_a = 36'(a06); mul_b = g1; end
          4'd3: begin mul_a = 36'(a06); mul_b = g2_q; end
          4'd4: begin mul_a = 36'(a23); mul_b = g5_q; end
          4'd5: begin mul_a = 36'(a06); mul_b = g3_q; end
          4'd6: begin mul_a = 36'(a_q[4]); mul_b = g5_q; end
          4'd7: begin mul_a = 36'(a234); mul_b = g1; end
          4'd8: begin mul_a = 36'(a23); mul_b = g4_q; end
          default: begin mul_a = 36'(a157); mul_b = ONE_Q16; end
        endcase
      end
      ST_VMUL: begin
        mul_a = accr[51:16];
        mul_b = em[op[2:0]];
      end
      ST_XMUL: begin
        mul_a = (op == 4'd0) ? 36'(sa_q) : 36'(sb_q);
        mul_b = (op == 4'd0) ? clampq(wa_q) : clampq(wb_q);
      end
      ST_TMUL: begin
        mul_a = 36'(lnrr[62:28]);
        mul_b = {1'b0, weight_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= 53'(mul_a) * 53'(mul_b);
  end

  // renormalization
  logic [5:0]  pos_mx, r_raw, r_eff;
  logic [15:0] sc, sc_new, room;
  logic        shr_d;

  always_comb begin
    pos_mx = '0;
    for (int i = 0; i < 36; i++) begin
      if (mx_q[i]) pos_mx = 6'(i);
    end
    sc     = scale_q[chain_q];
    room   = 16'hFFFF - sc;
    r_raw  = '0;
    r_eff  = '0;
    shr_d  = 1'b0;
    sc_new = sc;
    if (|mx_q[35:32]) begin
      r_raw  = pos_mx - 6'd31;
      r_eff  = (16'(r_raw) > sc) ? sc[5:0] : r_raw;
      sc_new = sc - 16'(r_eff);
      shr_d  = 1'b1;
    end else if (mx_q != '0) begin
      r_raw  = 6'd31 - pos_mx;
      r_eff  = (16'(r_raw) > room) ? room[5:0] : r_raw;
      sc_new = sc + 16'(r_eff);
    end
  end

  logic [35:0] vv, vrs, vls;
  assign vv     = v_q[cnt_q[2:0]];
  assign vrs    = vv >> r_q;
  assign vls    = vv << r_q;
  assign awe    = (state_q == ST_WR);
  assign awaddr = {chain_q, cnt_q[2:0]};
  assign awdata = shr_q ? ((|vrs[35:32]) ? 32'hFFFF_FFFF : vrs[31:0]) : vls[31:0];

  // end path
  logic [15:0] sf, ss, smin, d0, d1;
  logic [51:0] xas, xbs;
  logic [5:0]  pos_x;
  logic [52:0] xsh;
  logic [61:0] sq;
  logic [31:0] sqt;
  logic signed [19:0] diff;
  logic signed [39:0] l2;
  logic [31:0] term_d;
  logic signed [48:0] tot;
  logic [47:0] tot_sat;
  logic        fin_go;

  always_comb begin
    sf    = scale_q[0];
    ss    = scale_q[1];
    smin  = (sf < ss) ? sf : ss;
    d0    = sf - smin;
    d1    = ss - smin;
    xas   = (d0 < 16'd64) ? (xa_q >> d0[5:0]) : '0;
    xbs   = (d1 < 16'd64) ? (xb_q >> d1[5:0]) : '0;
    pos_x = '0;
    for (int i = 0; i < 53; i++) begin
      if (x_q[i]) pos_x = 6'(i);
    end
    xsh   = (pos_x >= 6'd30) ? (x_q >> 6'(pos_x - 6'd30)) : (x_q << 6'(6'd30 - pos_x));
    sq    = 62'(m_q) * 62'(m_q);
    sqt   = sq[61:30];
    diff  = $signed({14'd0, p_q}) - 20'sd47 - $signed({4'd0, smin_q});
    l2    = $signed({diff, 20'd0}) + $signed({20'd0, frac_q});
    if (zero_q) begin
      term_d = (weight_q != 16'd0) ? 32'h8000_0000 : 32'd0;
    end else if (neg_q) begin
      term_d = (tmag_q > 50'h0_8000_0000) ? 32'h8000_0000 : 32'(50'd0 - tmag_q);
    end else begin
      term_d = (tmag_q > 50'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : tmag_q[31:0];
    end
    tot = $signed({running_q[47], running_q}) + $signed({{17{term_d[31]}}, term_d});
    case (tot[48:47])
      2'b01:   tot_sat = 48'h7FFF_FFFF_FFFF;
      2'b10:   tot_sat = 48'h8000_0000_0000;
      default: tot_sat = tot[47:0];
    endcase
    fin_go = (state_q == ST_FIN) && (!out_valid_q || m_axis_tready);
  end

  // control and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      chain_q     <= 1'b0;
      out_valid_q <= 1'b0;
      avld_q      <= '0;
      scale_q     <= '0;
      running_q   <= '0;
      levels_q    <= 3'd4;
      wa_q        <= 17'd32768;
      wb_q        <= 17'd32768;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_LEVELS: levels_q <= cfg_data_i[2:0];
          CFG_MIX_A:  wa_q <= cfg_data_i;
          CFG_MIX_B:  wb_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (fin_go) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            cnt_q <= '0;
            case (in_mode)
              MODE_BEGIN: begin
                avld_q  <= '0;
                scale_q <= '0;
              end
              MODE_STEP: state_q <= ST_GCALC;
              MODE_END:  state_q <= ST_SUMRD;
              default: ;
            endcase
          end
        end
        ST_GCALC: begin
          if (cnt_q == 5'd11) begin
            state_q <= ST_RD; cnt_q <= '0; chain_q <= 1'b0;
          end else cnt_q <= cnt_q + 5'd1;
        end
        ST_RD: begin
          if (cnt_q == 5'd8) begin
            state_q <= ST_ACC; cnt_q <= '0;
          end else cnt_q <= cnt_q + 5'd1;
        end
        ST_ACC: begin
          if (cnt_q == 5'd19) begin
            state_q <= ST_VMUL; cnt_q <= '0;
          end else cnt_q <= cnt_q + 5'd1;
        end
        ST_VMUL: begin
          if (cnt_q == 5'd15) begin
            state_q <= ST_NORM; cnt_q <= '0;
          end else cnt_q <= cnt_q + 5'd1;
        end
        ST_NORM: begin
          scale_q[chain_q] <= sc_new;
          state_q <= ST_WR;
        end
        ST_WR: begin
          avld_q[awaddr] <= 1'b1;
          if (cnt_q == 5'd7) begin
            cnt_q <= '0;
            if (!chain_q) begin
              chain_q <= 1'b1; state_q <= ST_RD;
            end else state_q <= ST_IDLE;
          end else cnt_q <= cnt_q + 5'd1;
        end
        ST_SUMRD: begin
          if (cnt_q == 5'd16) begin
            state_q <= ST_XMUL; cnt_q <= '0;
          end else cnt_q <= cnt_q + 5'd1;
        end
        ST_XMUL: begin
          if (cnt_q == 5'd3) begin
            state_q <= ST_ALIGN; cnt_q <= '0;
          end else cnt_q <= cnt_q + 5'd1;
        end
        ST_ALIGN: state_q <= ST_LOGN;
        ST_LOGN: begin
          cnt_q   <= '0;
          state_q <= (x_q == '0) ? ST_FIN : ST_LOGSQ;
        end
        ST_LOGSQ: begin
          if (cnt_q == 5'd19) begin
            state_q <= ST_LNMUL; cnt_q <= '0;
          end else cnt_q <= cnt_q + 5'd1;
        end
        ST_LNMUL: begin
          if (cnt_q == 5'd1) begin
            state_q <= ST_TMUL; cnt_q <= '0;
          end else cnt_q <= cnt_q + 5'd1;
        end
        ST_TMUL: begin
          if (cnt_q == 5'd1) begin
            state_q <= ST_FIN; cnt_q <= '0;
          end else cnt_q <= cnt_q + 5'd1;
        end
        ST_FIN: begin
          if (fin_go) begin
            running_q   <= tot_sat;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    rdv_q  <= avld_q[araddr];
    rds0_q <= (araddr[2:0] == 3'd0);
    if (fin_go) begin
      term_q  <= term_d;
      total_q <= tot_sat;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          surv_q   <= clampq(s_axis_tdata[16:0]);
          entry_q  <= clampq(s_axis_tdata[33:17]);
          infect_q <= clampq(s_axis_tdata[50:34]);
          lam_q    <= clampq(s_axis_tdata[67:51]);
          obs_q    <= s_axis_tdata[77:68];
          combo_q  <= s_axis_tdata[85:78];
          e1_q     <= clampq(s_axis_tdata[102:86]);
          e2_q     <= clampq(s_axis_tdata[119:103]);
          e3_q     <= clampq(s_axis_tdata[136:120]);
          weight_q <= s_axis_tdata[152:137];
          sa_q     <= '0;
          sb_q     <= '0;
        end
      end
      ST_GCALC: begin
        if (ph) begin
          case (op)
            4'd0: g0_q <= rq[16:0];
            4'd1: sej_q <= rq[16:0];
            4'd2: g2_q <= rq[16:0];
            4'd3: g3_q <= rq[16:0];
            4'd4: g4_q <= rq[16:0];
            default: g5_q <= rq[16:0];
          endcase
        end
      end
      ST_RD: begin
        if (cnt_q != 5'd0) a_q[3'(cnt_q - 5'd1)] <= aval;
      end
      ST_ACC: begin
        if (ph) begin
          case (op)
            4'd0: acc_q[0] <= prod_q[50:0];
            4'd1: acc_q[0] <= acc_q[0] + prod_q[50:0];
            4'd2: acc_q[1] <= prod_q[50:0];
            4'd3: acc_q[2] <= prod_q[50:0];
            4'd4: acc_q[3] <= prod_q[50:0];
            4'd5: acc_q[4] <= prod_q[50:0];
            4'd6: acc_q[4] <= acc_q[4] + prod_q[50:0];
            4'd7: acc_q[5] <= prod_q[50:0];
            4'd8: acc_q[6] <= prod_q[50:0];
            default: acc_q[7] <= prod_q[50:0];
          endcase
        end
      end
      ST_VMUL: begin
        if (ph) begin
          v_q[op[2:0]] <= rq[35:0];
          if (op == 4'd0 || rq[35:0] > mx_q) mx_q <= rq[35:0];
        end
      end
      ST_NORM: begin
        r_q   <= r_eff;
        shr_q <= shr_d;
      end
      ST_SUMRD: begin
        if (cnt_q != 5'd0) begin
          if (cnt_q[4] || cnt_q[3] && (cnt_q[2:0] != 3'd0)) sb_q <= sb_q + 35'(aval);
          else sa_q <= sa_q + 35'(aval);
        end
      end
      ST_XMUL: begin
        if (ph) begin
          if (op == 4'd0) xa_q <= prod_q[51:0];
          else xb_q <= prod_q[51:0];
        end
      end
      ST_ALIGN: begin
        x_q    <= 53'(xas) + 53'(xbs);
        smin_q <= smin;
      end
      ST_LOGN: begin
        zero_q <= (x_q == '0);
        p_q    <= pos_x;
        m_q    <= xsh[30:0];
        frac_q <= '0;
      end
      ST_LOGSQ: begin
        frac_q <= {frac_q[18:0], sqt[31]};
        m_q    <= sqt[31] ? sqt[31:1] : sqt[30:0];
      end
      ST_LNMUL: begin
        if (cnt_q == 5'd0) begin
          neg_q <= l2[39];
          mag_q <= l2[39] ? 39'(-l2) : l2[38:0];
        end else begin
          lnp_q <= 63'(mag_q) * 63'(LN2_Q24);
        end
      end
      ST_TMUL: begin
        if (ph) tmag_q <= prod_q[49:0];
      end
      default: ;
    endcase
  end

  a_step_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_mode == MODE_STEP) |=> (state_q == ST_GCALC))
    else $error("step transfer did not start the transition pass");

  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_FIN))
    else $error("result shown outside the finish state");

  a_scale_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_NORM && mx_q == '0) |=> $stable(scale_q))
    else $error("scale moved on an all-zero alpha");

  a_log_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOGSQ) |-> m_q[30])
    else $error("log mantissa lost normalization");

endmodule

// ===== rtl/core/hmmfwd_ram.sv =====
// generic single write port ram with registered read
module hmmfwd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
